// ===== hw/rtl/acc_pkg.sv =====
// Shared types, codes and reset values of the awning command controller.
package acc_pkg;

    localparam int ADC_BITS_DEF    = 10;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int SAMPLE_W        = 10;
    localparam int MAX_BEATS       = 3;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_SERIAL = 2'd0;
    localparam t_opcode OP_TEMP   = 2'd1;
    localparam t_opcode OP_LIGHT  = 2'd2;
    localparam t_opcode OP_DIST   = 2'd3;

    localparam logic [7:0] CMD_GET_TEMP        = 8'd21;
    localparam logic [7:0] CMD_GET_TEMP_LIMIT  = 8'd22;
    localparam logic [7:0] CMD_GET_LIGHT       = 8'd23;
    localparam logic [7:0] CMD_GET_LIGHT_LIMIT = 8'd24;
    localparam logic [7:0] CMD_GET_MAX_DOWN    = 8'd25;
    localparam logic [7:0] CMD_GET_MIN_DOWN    = 8'd26;
    localparam logic [7:0] CMD_GET_ROLLED_UP   = 8'd27;
    localparam logic [7:0] CMD_GET_DISTANCE    = 8'd28;
    localparam logic [7:0] CMD_GET_MOTION      = 8'd29;
    localparam logic [7:0] CMD_SET_TEMP_LIMIT  = 8'd41;
    localparam logic [7:0] CMD_SET_LIGHT_LIMIT = 8'd42;
    localparam logic [7:0] CMD_SET_MAX_DOWN    = 8'd43;
    localparam logic [7:0] CMD_SET_MIN_DOWN    = 8'd44;
    localparam logic [7:0] CMD_MARK_DOWN       = 8'd45;
    localparam logic [7:0] CMD_MARK_UP         = 8'd46;
    localparam logic [7:0] CMD_MANUAL          = 8'd47;
    localparam logic [7:0] CMD_AUTOMATIC       = 8'd48;
    localparam logic [7:0] CMD_START_ROLL      = 8'd50;

    localparam logic [7:0] RPL_ONE_BYTE  = 8'd12;
    localparam logic [7:0] RPL_TWO_BYTES = 8'd13;
    localparam logic [7:0] RPL_DONE      = 8'd11;
    localparam logic [7:0] RPL_ZERO      = 8'd2;

    typedef enum logic [2:0] {
        PEND_NONE  = 3'd0,
        PEND_TEMP  = 3'd1,
        PEND_LIGHT = 3'd2,
        PEND_MAXD  = 3'd3,
        PEND_MIND  = 3'd4
    } t_pend;

    localparam logic [7:0]  RST_TEMP_LIMIT  = 8'd174;
    localparam logic [15:0] RST_LIGHT_LIMIT = 16'd500;
    localparam logic [15:0] RST_MAX_DOWN    = 16'd400;
    localparam logic [15:0] RST_MIN_DOWN    = 16'd40;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [7:0]          rx_byte;
        logic [SAMPLE_W-1:0] sample;
        logic [15:0]         distance;
    } t_cmd;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] tx_byte;
        logic       last;
        logic       red_led;
        logic       green_led;
        logic       moving;
    } t_rsp;

    typedef struct packed {
        logic [1:0]                     last_idx;
        logic                           has_byte;
        logic [MAX_BEATS-1:0][7:0]      bytes;
        logic                           red;
        logic                           green;
        logic                           moving;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_q_head;

endpackage

// ===== hw/rtl/acc_stream_if.sv =====
// Valid/ready stream channel carrying one payload per beat.
interface acc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/awning_command_controller.sv =====
// Top level of the awning command controller.
//
// Input channel i_cmd carries one item per beat: a serial command byte, a
// temperature or light sample, or a distance measurement. Output channel
// o_rsp carries result beats; each item yields one to three beats, the last
// one flagged by last, and every beat shows the lamps and motion flag as
// they stand after the item.
// The front end handles an accepted item in the cycle of acceptance and
// writes one reply record into a queue of QUEUE_DEPTH entries, where it is
// registered. The back end sends one beat per cycle while the receiver is
// ready; an item has one beat for sensor events and most commands, two or
// three for read-back commands, and the front end takes a new item every
// cycle while the queue has room.
// Reset restores the default limits and state, rolled up with the red lamp
// on, and empties the queue. When the receiver stalls, the current beat is
// held, the queue fills, and i_cmd.ready drops until space frees up.
module awning_command_controller #(
    parameter int ADC_BITS    = acc_pkg::ADC_BITS_DEF,
    parameter int QUEUE_DEPTH = acc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    acc_stream_if.sink   i_cmd,
    acc_stream_if.source o_rsp
);
    import acc_pkg::*;

    logic    push;
    logic    pop;
    logic    q_full;
    t_rec    rec;
    t_q_head head;
    t_rsp    rsp;

    acc_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_q_full (q_full),
        .o_push   (push),
        .o_rec    (rec)
    );

    acc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    acc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

    assign rsp = o_rsp.data;

    a_lamps_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(rsp.red_led && rsp.green_led))
        else $error("both lamps lit in one beat");

    a_moving_lamps_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && rsp.moving) |-> (!rsp.red_led && !rsp.green_led))
        else $error("lamp lit while rolling");

    a_multi_beat_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !rsp.last) |-> rsp.has_byte)
        else $error("non-final beat without a reply byte");

    a_empty_beat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !rsp.has_byte) |-> (rsp.tx_byte == 8'd0))
        else $error("empty beat carries a nonzero byte");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("queue written while full");
endmodule

// ===== hw/rtl/acc_front.sv =====
// Front end: accepts input items, updates controller state and builds reply records.
module acc_front #(
    parameter int ADC_BITS = acc_pkg::ADC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    acc_stream_if.sink    i_cmd,
    input  logic          i_q_full,
    output logic          o_push,
    output acc_pkg::t_rec o_rec
);
    import acc_pkg::*;

    localparam logic [SAMPLE_W-1:0] SampleMask = (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}}
        : SAMPLE_W'((32'd1 << ADC_BITS) - 32'd1);

    logic                r_rolled_up, n_rolled_up;
    logic                r_manual, n_manual;
    logic                r_motion, n_motion;
    logic [7:0]          r_temp_limit, n_temp_limit;
    logic [15:0]         r_light_limit, n_light_limit;
    logic [15:0]         r_max_down, n_max_down;
    logic [15:0]         r_min_down, n_min_down;
    logic [SAMPLE_W-1:0] r_last_temp, n_last_temp;
    logic [SAMPLE_W-1:0] r_last_light, n_last_light;
    logic [15:0]         r_last_dist, n_last_dist;
    t_pend               r_pend, n_pend;
    logic                r_phase, n_phase;
    logic [7:0]          r_held, n_held;
    logic                r_red, n_red;
    logic                r_green, n_green;

    t_cmd                cmd;
    logic [SAMPLE_W-1:0] smp;
    logic [15:0]         word;
    logic [15:0]         light_word;
    logic [15:0]         roll_limit;
    t_rec                rec;

    assign cmd         = i_cmd.data;
    assign i_cmd.ready = !i_q_full;
    assign o_push      = i_cmd.valid && !i_q_full;
    assign smp         = cmd.sample & SampleMask;
    assign word        = {r_held, cmd.rx_byte};
    assign light_word  = 16'(r_last_light);
    assign roll_limit  = r_rolled_up ? r_min_down : (r_max_down - r_min_down);

    always_comb begin
        n_rolled_up   = r_rolled_up;
        n_manual      = r_manual;
        n_motion      = r_motion;
        n_temp_limit  = r_temp_limit;
        n_light_limit = r_light_limit;
        n_max_down    = r_max_down;
        n_min_down    = r_min_down;
        n_last_temp   = r_last_temp;
        n_last_light  = r_last_light;
        n_last_dist   = r_last_dist;
        n_pend        = r_pend;
        n_phase       = r_phase;
        n_held        = r_held;
        n_red         = r_red;
        n_green       = r_green;
        rec           = '0;

        case (cmd.opcode)
            OP_SERIAL: begin
                if (r_pend != PEND_NONE) begin
                    case (r_pend)
                        PEND_TEMP: begin
                            n_temp_limit  = cmd.rx_byte;
                            n_pend        = PEND_NONE;
                            rec.has_byte  = 1'b1;
                            rec.bytes[0]  = (cmd.rx_byte == 8'd0) ? RPL_ZERO : RPL_ONE_BYTE;
                        end
                        PEND_LIGHT, PEND_MAXD, PEND_MIND: begin
                            if (!r_phase) begin
                                n_held  = cmd.rx_byte;
                                n_phase = 1'b1;
                            end else begin
                                n_phase      = 1'b0;
                                n_pend       = PEND_NONE;
                                rec.has_byte = 1'b1;
                                if (r_pend == PEND_LIGHT) begin
                                    n_light_limit = word;
                                    rec.bytes[0]  = RPL_ONE_BYTE;
                                end else begin
                                    if (r_pend == PEND_MAXD) begin
                                        n_max_down = word;
                                    end else begin
                                        n_min_down = word;
                                    end
                                    rec.bytes[0] = (word == 16'd0) ? RPL_ZERO : RPL_DONE;
                                end
                            end
                        end
                        default: begin
                            n_pend  = PEND_NONE;
                            n_phase = 1'b0;
                        end
                    endcase
                end else begin
                    case (cmd.rx_byte)
                        CMD_GET_TEMP, CMD_GET_TEMP_LIMIT, CMD_GET_ROLLED_UP,
                        CMD_GET_MOTION: begin
                            rec.has_byte = 1'b1;
                            rec.last_idx = 2'd1;
                            rec.bytes[0] = RPL_ONE_BYTE;
                            if (cmd.rx_byte == CMD_GET_TEMP) begin
                                rec.bytes[1] = r_last_temp[7:0];
                            end else if (cmd.rx_byte == CMD_GET_TEMP_LIMIT) begin
                                rec.bytes[1] = r_temp_limit;
                            end else if (cmd.rx_byte == CMD_GET_ROLLED_UP) begin
                                rec.bytes[1] = {7'd0, r_rolled_up};
                            end else begin
                                rec.bytes[1] = {7'd0, r_motion};
                            end
                        end
                        CMD_GET_LIGHT: begin
                            rec.has_byte = 1'b1;
                            rec.last_idx = 2'd2;
                            rec.bytes    = {light_word[7:0], light_word[15:8], RPL_TWO_BYTES};
                        end
                        CMD_GET_LIGHT_LIMIT: begin
                            rec.has_byte = 1'b1;
                            rec.last_idx = 2'd2;
                            rec.bytes    = {r_light_limit[7:0], r_light_limit[15:8],
                                            RPL_TWO_BYTES};
                        end
                        CMD_GET_MAX_DOWN: begin
                            rec.has_byte = 1'b1;
                            rec.last_idx = 2'd2;
                            rec.bytes    = {r_max_down[7:0], r_max_down[15:8], RPL_TWO_BYTES};
                        end
                        CMD_GET_MIN_DOWN: begin
                            rec.has_byte = 1'b1;
                            rec.last_idx = 2'd2;
                            rec.bytes    = {r_min_down[7:0], r_min_down[15:8], RPL_TWO_BYTES};
                        end
                        CMD_GET_DISTANCE: begin
                            rec.has_byte = 1'b1;
                            rec.last_idx = 2'd2;
                            rec.bytes    = {r_last_dist[7:0], r_last_dist[15:8],
                                            RPL_TWO_BYTES};
                        end
                        CMD_SET_TEMP_LIMIT: begin
                            n_pend  = PEND_TEMP;
                            n_phase = 1'b0;
                        end
                        CMD_SET_LIGHT_LIMIT: begin
                            n_pend  = PEND_LIGHT;
                            n_phase = 1'b0;
                        end
                        CMD_SET_MAX_DOWN: begin
                            n_pend  = PEND_MAXD;
                            n_phase = 1'b0;
                        end
                        CMD_SET_MIN_DOWN: begin
                            n_pend  = PEND_MIND;
                            n_phase = 1'b0;
                        end
                        CMD_MARK_DOWN, CMD_MARK_UP: begin
                            n_rolled_up  = (cmd.rx_byte == CMD_MARK_UP);
                            rec.has_byte = 1'b1;
                            rec.bytes[0] = RPL_DONE;
                            if (!r_motion) begin
                                n_red   = n_rolled_up;
                                n_green = !n_rolled_up;
                            end
                        end
                        CMD_MANUAL, CMD_AUTOMATIC: begin
                            n_manual     = (cmd.rx_byte == CMD_MANUAL);
                            rec.has_byte = 1'b1;
                            rec.bytes[0] = RPL_DONE;
                        end
                        CMD_START_ROLL: begin
                            n_motion     = 1'b1;
                            n_red        = 1'b0;
                            n_green      = 1'b0;
                            rec.has_byte = 1'b1;
                            rec.bytes[0] = RPL_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_TEMP: begin
                n_last_temp = smp;
                if (!r_manual && r_rolled_up && (smp >= SAMPLE_W'(r_temp_limit))) begin
                    n_motion = 1'b1;
                    n_red    = 1'b0;
                    n_green  = 1'b0;
                end
            end
            OP_LIGHT: begin
                n_last_light = smp;
                if (!r_manual && r_rolled_up && (16'(smp) >= r_light_limit)) begin
                    n_motion = 1'b1;
                    n_red    = 1'b0;
                    n_green  = 1'b0;
                end
            end
            default: begin
                n_last_dist = cmd.distance;
                if (r_motion && (cmd.distance < roll_limit)) begin
                    n_motion    = 1'b0;
                    n_rolled_up = !r_rolled_up;
                    n_red       = !r_rolled_up;
                    n_green     = r_rolled_up;
                end
            end
        endcase

        rec.red    = n_red;
        rec.green  = n_green;
        rec.moving = n_motion;
    end

    assign o_rec = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rolled_up   <= 1'b1;
            r_manual      <= 1'b0;
            r_motion      <= 1'b0;
            r_temp_limit  <= RST_TEMP_LIMIT;
            r_light_limit <= RST_LIGHT_LIMIT;
            r_max_down    <= RST_MAX_DOWN;
            r_min_down    <= RST_MIN_DOWN;
            r_last_temp   <= '0;
            r_last_light  <= '0;
            r_last_dist   <= '0;
            r_pend        <= PEND_NONE;
            r_phase       <= 1'b0;
            r_held        <= '0;
            r_red         <= 1'b1;
            r_green       <= 1'b0;
        end else if (o_push) begin
            r_rolled_up   <= n_rolled_up;
            r_manual      <= n_manual;
            r_motion      <= n_motion;
            r_temp_limit  <= n_temp_limit;
            r_light_limit <= n_light_limit;
            r_max_down    <= n_max_down;
            r_min_down    <= n_min_down;
            r_last_temp   <= n_last_temp;
            r_last_light  <= n_last_light;
            r_last_dist   <= n_last_dist;
            r_pend        <= n_pend;
            r_phase       <= n_phase;
            r_held        <= n_held;
            r_red         <= n_red;
            r_green       <= n_green;
        end
    end
endmodule

// ===== hw/rtl/acc_queue.sv =====
// Small register queue of reply records between the front and back ends.
module acc_queue #(
    parameter int DEPTH = acc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  acc_pkg::t_rec    i_rec,
    input  logic             i_pop,
    output logic             o_full,
    output acc_pkg::t_q_head o_head
);
    import acc_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_rec            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt;
    logic            pop;

    assign o_full      = (r_cnt == CntW'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.rec   = r_mem[r_rd];
    assign pop          = i_pop && o_head.valid;
    assign n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + PtrW'(1);
    assign n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + PtrW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end
endmodule

// ===== hw/rtl/acc_back.sv =====
// Back end: sends the beats of the reply record at the head of the queue.
module acc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  acc_pkg::t_q_head i_head,
    output logic             o_pop,
    acc_stream_if.source     o_rsp
);
    import acc_pkg::*;

    logic [1:0] r_idx;
    logic       is_last;
    t_rsp       rsp;

    assign is_last = (r_idx == i_head.rec.last_idx);

    always_comb begin
        rsp.has_byte  = i_head.rec.has_byte;
        rsp.tx_byte   = i_head.rec.has_byte ? i_head.rec.bytes[r_idx] : 8'd0;
        rsp.last      = is_last;
        rsp.red_led   = i_head.rec.red;
        rsp.green_led = i_head.rec.green;
        rsp.moving    = i_head.rec.moving;
    end

    assign o_rsp.valid = i_head.valid;
    assign o_rsp.data  = rsp;
    assign o_pop       = i_head.valid && o_rsp.ready && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_head.valid && o_rsp.ready) begin
            r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
        end
    end
endmodule
